>>> hdl/keyword_lexer_stream_assert.svh
// Assertion macros shared by the keyword lexer RTL.
// Depends on nothing; included inside module bodies.
`ifndef KEYWORD_LEXER_STREAM_ASSERT_SVH
`define KEYWORD_LEXER_STREAM_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define KLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keyword lexer check failed");

// Implication in the following cycle, checked outside reset.
`define KLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keyword lexer check failed");

`endif

>>> hdl/kls_pkg.sv
// Shared types, token codes and character helpers for the keyword lexer.
// Depends on nothing.
package kls_pkg;

    localparam int KLS_TOKEN_CHARS = 16;

    localparam logic [4:0] KIND_ERROR  = 5'd0;
    localparam logic [4:0] KIND_IDENT  = 5'd10;
    localparam logic [4:0] KIND_CONST  = 5'd11;
    localparam logic [4:0] KIND_EQ     = 5'd12;
    localparam logic [4:0] KIND_NE     = 5'd13;
    localparam logic [4:0] KIND_LE     = 5'd14;
    localparam logic [4:0] KIND_LT     = 5'd15;
    localparam logic [4:0] KIND_GE     = 5'd16;
    localparam logic [4:0] KIND_GT     = 5'd17;
    localparam logic [4:0] KIND_MINUS  = 5'd18;
    localparam logic [4:0] KIND_STAR   = 5'd19;
    localparam logic [4:0] KIND_ASSIGN = 5'd20;
    localparam logic [4:0] KIND_LPAREN = 5'd21;
    localparam logic [4:0] KIND_RPAREN = 5'd22;
    localparam logic [4:0] KIND_SEMI   = 5'd23;
    localparam logic [4:0] KIND_EOLN   = 5'd24;
    localparam logic [4:0] KIND_EOF    = 5'd25;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_COLON = 2'd1;
    localparam logic [1:0] ERR_CHAR  = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BANG   = 8'h21;

    // Fixed token texts, first character in the low byte.
    localparam logic [63:0] TEXT_EOLN = 64'h0000_0000_4E4C_4F45;
    localparam logic [63:0] TEXT_EOF  = 64'h0000_0000_0046_4F45;

    // Keywords as string literals: first character in the highest used byte.
    localparam int KW_COUNT = 9;
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("begin"), 64'("end"), 64'("integer"), 64'("if"), 64'("then"),
        64'("else"), 64'("function"), 64'("read"), 64'("write")
    };
    localparam int KW_LEN [KW_COUNT] = '{5, 3, 7, 2, 4, 4, 8, 4, 5};

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [63:0] text_low;
        logic [63:0] text_high;
        logic [4:0]  text_length;
        logic        too_long;
        logic [15:0] line_number;
        logic [1:0]  error_kind;
        logic [7:0]  bad_char;
        logic        last;
    } t_result;

    function automatic logic is_alpha_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Keyword code 1..9 for the first eight buffered characters, 0 if none.
    function automatic logic [4:0] kw_code(input logic [63:0] text,
                                           input logic [4:0] len);
        logic [4:0] code;
        logic       same;
        code = KIND_ERROR;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            same = (len == 5'(KW_LEN[k]));
            for (int i = 0; i < 8; i++) begin
                if (i < KW_LEN[k] &&
                    text[i*8 +: 8] != KW_TEXT[k][(KW_LEN[k]-1-i)*8 +: 8]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                code = 5'(k + 1);
            end
        end
        return code;
    endfunction

endpackage

>>> hdl/kls_if.sv
// Request channel interfaces of the keyword lexer: input bytes and tokens.
// Depends on kls_pkg.
interface kls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_text;

    modport source (output valid, char_byte, end_of_text, input ready);
    modport sink (input valid, char_byte, end_of_text, output ready);
endinterface

interface kls_out_if;
    import kls_pkg::*;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [63:0] text_low;
    logic [63:0] text_high;
    logic [4:0]  text_length;
    logic        too_long;
    logic [15:0] line_number;
    logic [1:0]  error_kind;
    logic [7:0]  bad_char;
    logic        last;

    modport source (output valid, token_kind, text_low, text_high, text_length,
                    too_long, line_number, error_kind, bad_char, last,
                    input ready);
    modport sink (input valid, token_kind, text_low, text_high, text_length,
                  too_long, line_number, error_kind, bad_char, last,
                  output ready);
endinterface

>>> hdl/kls_scan.sv
// Scanner core: mode, token buffer and line counter, and the up to two
// results one byte causes. Depends on kls_pkg and the assertion header.
module kls_scan #(
    parameter int TOKEN_CHARS = kls_pkg::KLS_TOKEN_CHARS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_char,
    input  logic              i_eot,
    output kls_pkg::t_result  o_res_a,
    output kls_pkg::t_result  o_res_b,
    output logic [1:0]        o_res_count
);
    import kls_pkg::*;
    `include "keyword_lexer_stream_assert.svh"

    localparam int BW = TOKEN_CHARS * 8;
    localparam int CW = $clog2(TOKEN_CHARS + 1);

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_NUM, M_LT, M_GT, M_COLON
    } t_mode;

    t_mode          r_mode, n_mode;
    logic [BW-1:0]  r_buf, n_buf;
    logic [CW-1:0]  r_count, n_count;
    logic           r_ovf, n_ovf;
    logic [15:0]    r_line, n_line;

    logic [BW-1:0]  w_buf_app;
    logic [CW-1:0]  w_cnt_app;
    logic           w_ovf_app;
    logic [4:0]     w_kw;
    logic           w_cont, w_pair;
    logic [4:0]     w_pair_kind, w_single_kind;
    logic [15:0]    w_line_inc;
    t_result        w_flush, w_start, w_a, w_b;
    logic           w_flush_v, w_start_v;

    function automatic t_result make_tok(input logic [4:0] kind,
                                         input logic [BW-1:0] text,
                                         input logic [CW-1:0] cnt,
                                         input logic ovf,
                                         input logic [15:0] line);
        t_result     r;
        logic [127:0] wide;
        wide          = 128'(text);
        r             = '0;
        r.token_kind  = kind;
        r.text_low    = wide[63:0];
        r.text_high   = wide[127:64];
        r.text_length = 5'(cnt);
        r.too_long    = ovf;
        r.line_number = line;
        return r;
    endfunction

    function automatic t_result make_err(input logic [1:0] err,
                                         input logic [7:0] bad,
                                         input logic [15:0] line);
        t_result r;
        r             = '0;
        r.error_kind  = err;
        r.bad_char    = bad;
        r.line_number = line;
        return r;
    endfunction

    // Append the current byte to the held token.
    always_comb begin
        w_buf_app = r_buf;
        for (int i = 0; i < TOKEN_CHARS; i++) begin
            if (r_count == CW'(i)) begin
                w_buf_app[i*8 +: 8] = i_char;
            end
        end
        w_cnt_app = (r_count < CW'(TOKEN_CHARS)) ? r_count + 1'b1 : r_count;
        w_ovf_app = r_ovf | (r_count >= CW'(TOKEN_CHARS));
    end

    assign w_kw       = r_ovf ? KIND_ERROR : kw_code(r_buf[63:0], 5'(r_count));
    assign w_line_inc = (r_line != 16'hFFFF) ? r_line + 16'd1 : r_line;

    assign w_cont = (r_mode == M_IDENT && (is_alpha_char(i_char) || is_digit(i_char)))
                  || (r_mode == M_NUM && is_digit(i_char));
    assign w_pair = (r_mode == M_LT && (i_char == CH_EQ || i_char == CH_GT))
                  || ((r_mode == M_GT || r_mode == M_COLON) && i_char == CH_EQ);

    always_comb begin
        case (r_mode)
            M_LT:    w_pair_kind = (i_char == CH_EQ) ? KIND_LE : KIND_NE;
            M_GT:    w_pair_kind = KIND_GE;
            default: w_pair_kind = KIND_ASSIGN;
        endcase
    end

    always_comb begin
        case (i_char)
            CH_EQ:             w_single_kind = KIND_EQ;
            CH_MINUS:          w_single_kind = KIND_MINUS;
            CH_STAR:           w_single_kind = KIND_STAR;
            CH_LPAREN:         w_single_kind = KIND_LPAREN;
            CH_RPAREN:         w_single_kind = KIND_RPAREN;
            CH_SEMI, CH_BANG:  w_single_kind = KIND_SEMI;
            default:           w_single_kind = KIND_ERROR;
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_buf     = r_buf;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_line    = r_line;
        w_start_v = 1'b0;
        w_start   = '0;

        // Result of the pending token, used unless the byte extends or completes it.
        w_flush_v = 1'b1;
        case (r_mode)
            M_IDENT: w_flush = make_tok((w_kw != KIND_ERROR) ? w_kw : KIND_IDENT,
                                        r_buf, r_count, r_ovf, r_line);
            M_NUM:   w_flush = make_tok(KIND_CONST, r_buf, r_count, r_ovf, r_line);
            M_LT:    w_flush = make_tok(KIND_LT, r_buf, r_count, r_ovf, r_line);
            M_GT:    w_flush = make_tok(KIND_GT, r_buf, r_count, r_ovf, r_line);
            M_COLON: w_flush = make_err(ERR_COLON, 8'h00, r_line);
            default: begin
                w_flush   = '0;
                w_flush_v = 1'b0;
            end
        endcase

        if (i_eot) begin
            w_start_v             = 1'b1;
            w_start               = '0;
            w_start.token_kind    = KIND_EOF;
            w_start.text_low      = TEXT_EOF;
            w_start.text_length   = 5'd3;
            w_start.line_number   = r_line;
            n_mode  = M_IDLE;
            n_buf   = '0;
            n_count = '0;
            n_ovf   = 1'b0;
            n_line  = '0;
        end else if (w_cont) begin
            w_flush_v = 1'b0;
            n_buf     = w_buf_app;
            n_count   = w_cnt_app;
            n_ovf     = w_ovf_app;
        end else if (w_pair) begin
            w_flush_v = 1'b0;
            w_start_v = 1'b1;
            w_start   = make_tok(w_pair_kind, w_buf_app, w_cnt_app, 1'b0, r_line);
            n_mode    = M_IDLE;
            n_buf     = '0;
            n_count   = '0;
            n_ovf     = 1'b0;
        end else begin
            // Drop the pending token into the flush slot, then start fresh.
            n_mode  = M_IDLE;
            n_buf   = '0;
            n_count = '0;
            n_ovf   = 1'b0;
            if (i_char inside {CH_SPACE, CH_TAB}) begin
                w_start_v = 1'b0;
            end else if (is_alpha_char(i_char) || is_digit(i_char)
                         || i_char inside {CH_LT, CH_GT, CH_COLON}) begin
                n_buf   = BW'(i_char);
                n_count = CW'(1);
                if (is_alpha_char(i_char)) begin
                    n_mode = M_IDENT;
                end else if (is_digit(i_char)) begin
                    n_mode = M_NUM;
                end else if (i_char == CH_LT) begin
                    n_mode = M_LT;
                end else if (i_char == CH_GT) begin
                    n_mode = M_GT;
                end else begin
                    n_mode = M_COLON;
                end
            end else if (i_char == CH_NL) begin
                n_line              = w_line_inc;
                w_start_v           = 1'b1;
                w_start             = '0;
                w_start.token_kind  = KIND_EOLN;
                w_start.text_low    = TEXT_EOLN;
                w_start.text_length = 5'd4;
                w_start.line_number = w_line_inc;
            end else if (w_single_kind != KIND_ERROR) begin
                w_start_v = 1'b1;
                w_start   = make_tok(w_single_kind, BW'(i_char), CW'(1), 1'b0, r_line);
            end else begin
                w_start_v = 1'b1;
                w_start   = make_err(ERR_CHAR, i_char, r_line);
            end
        end
    end

    // Pack the flush and start results in order and mark the final one.
    always_comb begin
        if (w_flush_v) begin
            w_a         = w_flush;
            w_b         = w_start;
            o_res_count = w_start_v ? 2'd2 : 2'd1;
        end else begin
            w_a         = w_start;
            w_b         = '0;
            o_res_count = w_start_v ? 2'd1 : 2'd0;
        end
        if (o_res_count == 2'd2) begin
            w_b.last = 1'b1;
        end else if (o_res_count == 2'd1) begin
            w_a.last = 1'b1;
        end
    end

    assign o_res_a = w_a;
    assign o_res_b = w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_buf   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_line  <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_buf   <= n_buf;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_line  <= n_line;
        end
    end

    `KLS_ASSERT_NEXT(a_eot_clears, i_clk, i_rst_n, i_step && i_eot,
        r_mode == M_IDLE && r_line == 16'd0 && r_count == '0)
    `KLS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(TOKEN_CHARS))
    `KLS_ASSERT_NOW(a_err_no_kind, i_clk, i_rst_n, o_res_a.error_kind != ERR_NONE,
        o_res_a.token_kind == KIND_ERROR && o_res_a.text_length == 5'd0)

endmodule

>>> hdl/keyword_lexer_stream.sv
// Keyword lexer top level: input register, scanner core, two-slot result buffer.
// Depends on kls_pkg, kls_in_if, kls_out_if, kls_scan and the assertion header.
//
// Use: the source feeds one ASCII byte per request on i_in (char_byte), or a
// request with end_of_text set to close the text. Tokens leave on o_out, one
// request each: keywords, identifiers, constants, operators, end of line and
// a final end of file, or an error with error_kind and bad_char. The last
// flag marks the final result one input byte caused; bytes that only extend
// a token, and blanks with no token pending, cause none.
// Path: a byte passes the input register, then the scanner writes its results
// into the result buffer in a single pass; a second result waits in slot 1
// and follows on o_out once the first is taken.
// Throughput: one byte per cycle while each byte gives at most one result and
// o_out is ready; a byte that both closes a token and emits its own holds the
// next byte until its second result drains through the single result port.
// Reset: synchronous, active low; clears scanner mode, token buffer, line
// count and both channels. End of text also returns the scanner to that state.
// Stall: when o_out is held off the buffer fills, the scanner holds its byte
// and i_in.ready drops; nothing is lost or repeated.
module keyword_lexer_stream #(
    parameter int TOKEN_CHARS = kls_pkg::KLS_TOKEN_CHARS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kls_in_if.sink     i_in,
    kls_out_if.source  o_out
);
    import kls_pkg::*;
    `include "keyword_lexer_stream_assert.svh"

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_eot;

    // Result buffer: slot 0 is on the output, slot 1 waits behind it.
    logic [1:0]  r_cnt;
    t_result     r_slot0, r_slot1;

    t_result     w_res_a, w_res_b;
    logic [1:0]  w_res_count;
    logic        w_pop, w_can_load, w_step;

    assign w_pop      = (r_cnt != 2'd0) && o_out.ready;
    // Load only into a buffer that is empty after this cycle.
    assign w_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && w_pop);
    assign w_step     = r_in_valid && w_can_load;
    assign i_in.ready = !r_in_valid || w_step;

    kls_scan #(
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_char      (r_in_char),
        .i_eot       (r_in_eot),
        .o_res_a     (w_res_a),
        .o_res_b     (w_res_b),
        .o_res_count (w_res_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            // Advance the input register whenever its byte moves on.
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
                if (i_in.valid) begin
                    r_in_char <= i_in.char_byte;
                    r_in_eot  <= i_in.end_of_text;
                end
            end
            if (w_step) begin
                r_slot0 <= w_res_a;
                r_slot1 <= w_res_b;
                r_cnt   <= w_res_count;
            end else if (w_pop) begin
                r_slot0 <= r_slot1;
                r_cnt   <= r_cnt - 2'd1;
            end
        end
    end

    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.token_kind  = r_slot0.token_kind;
    assign o_out.text_low    = r_slot0.text_low;
    assign o_out.text_high   = r_slot0.text_high;
    assign o_out.text_length = r_slot0.text_length;
    assign o_out.too_long    = r_slot0.too_long;
    assign o_out.line_number = r_slot0.line_number;
    assign o_out.error_kind  = r_slot0.error_kind;
    assign o_out.bad_char    = r_slot0.bad_char;
    assign o_out.last        = r_slot0.last;

    `KLS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_step,
        r_cnt == 2'd0 || w_pop)
    `KLS_ASSERT_NOW(a_last_order, i_clk, i_rst_n, w_step && w_res_count == 2'd2,
        !w_res_a.last && w_res_b.last)
    `KLS_ASSERT_NOW(a_hold_input, i_clk, i_rst_n, r_in_valid && !w_step,
        !i_in.ready)

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for keyword_lexer_stream: directed and random source text.
// Depends on kls_pkg, kls_in_if, kls_out_if and the keyword_lexer_stream RTL.
// An in-bench token predictor queues the expected tokens and checks each output request.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kls_pkg::*;

    localparam int RANDOM_ITEMS   = 940;
    localparam int HOLD_CYCLES    = 200;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LINE_RUN_COUNT = 40;

    // Keyword codes run from 1 in the order of the keyword table below.
    localparam logic [4:0] KIND_FIRST_KEYWORD = 5'd1;

    // Scanner modes of the predictor: what the held characters may still become.
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_NUMBER,
        SCAN_LESS,
        SCAN_GREATER,
        SCAN_COLON
    } t_scan;

    string kw_words [9] = '{"begin", "end", "integer", "if", "then", "else",
                            "function", "read", "write"};
    string op_words [13] = '{"=", "<>", "<=", "<", ">=", ">", "-", "*", ":=", "(", ")",
                             ";", "!"};

    logic i_clk = 1'b0;
    logic i_rst_n;

    kls_in_if  in_ch ();
    kls_out_if out_ch ();

    keyword_lexer_stream u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // 2 ns clock: high half, then low half.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Token predictor state: a private copy of the scanner.
    // ------------------------------------------------------------------
    t_scan         scan_mode;
    logic [127:0]  tok_text;
    logic [4:0]    tok_len;
    logic          tok_trunc;
    logic [15:0]   line_cnt;

    // Tokens still owed by the block, oldest first.
    t_result       pending_tokens [$];
    // The newest token of the current byte is held back until we know it is the last one.
    t_result       held;
    bit            have_held;

    int            fail_count;
    int            sent_count;
    bit            in_idle_on;
    bit            out_idle_on;
    bit            out_idle_allowed;
    int            hold_request;

    function automatic logic [63:0] text_of(input string s);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < s.len(); i++) begin
            v[i*8 +: 8] = s[i];
        end
        return v;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void clear_token();
        tok_text  = '0;
        tok_len   = '0;
        tok_trunc = 1'b0;
    endfunction

    function automatic void reset_predictor();
        clear_token();
        scan_mode = SCAN_IDLE;
        line_cnt  = '0;
    endfunction

    // Append one character; past the buffer size drop it and flag the truncation.
    function automatic void add_char(input logic [7:0] c);
        if (int'(tok_len) < KLS_TOKEN_CHARS) begin
            tok_text[int'(tok_len) * 8 +: 8] = c;
            tok_len = tok_len + 5'd1;
        end else begin
            tok_trunc = 1'b1;
        end
    endfunction

    // Queue one token; the line number is the count as it stands right now.
    function automatic void queue_token(input logic [4:0] kind, input logic [63:0] lo, hi,
                                        input logic [4:0] len, input logic trunc,
                                        input logic [1:0] err, input logic [7:0] bad);
        t_result r;
        r             = '0;
        r.token_kind  = kind;
        r.text_low    = lo;
        r.text_high   = hi;
        r.text_length = len;
        r.too_long    = trunc;
        r.line_number = line_cnt;
        r.error_kind  = err;
        r.bad_char    = bad;
        r.last        = 1'b0;
        if (have_held) begin
            pending_tokens.push_back(held);
        end
        held      = r;
        have_held = 1'b1;
    endfunction

    function automatic void emit_buffered(input logic [4:0] kind);
        queue_token(kind, tok_text[63:0], tok_text[127:64], tok_len, tok_trunc,
                    ERR_NONE, 8'h00);
        clear_token();
    endfunction

    // Keywords match only the complete, untruncated word, case sensitive.
    function automatic logic [4:0] word_kind();
        logic [4:0] kind;
        bit         same;
        kind = KIND_IDENT;
        for (int k = 0; k < 9; k++) begin
            same = !tok_trunc && (kw_words[k].len() == int'(tok_len));
            for (int i = 0; i < kw_words[k].len(); i++) begin
                if (same && tok_text[i*8 +: 8] != kw_words[k][i]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                kind = KIND_FIRST_KEYWORD + 5'(k);
            end
        end
        return kind;
    endfunction

    // Close whatever token is pending; a lone colon becomes an error.
    function automatic void flush_token();
        case (scan_mode)
            SCAN_WORD:    emit_buffered(word_kind());
            SCAN_NUMBER:  emit_buffered(KIND_CONST);
            SCAN_LESS:    emit_buffered(KIND_LT);
            SCAN_GREATER: emit_buffered(KIND_GT);
            SCAN_COLON: begin
                clear_token();
                queue_token(KIND_ERROR, '0, '0, '0, 1'b0, ERR_COLON, 8'h00);
            end
            default: ;
        endcase
        scan_mode = SCAN_IDLE;
    endfunction

    // Act on a byte with nothing pending.
    function automatic void start_char(input logic [7:0] c);
        logic [4:0] kind;
        kind = KIND_ERROR;
        clear_token();
        if (c == CH_SPACE || c == CH_TAB) begin
            return;
        end
        if (is_alpha(c)) begin
            add_char(c);
            scan_mode = SCAN_WORD;
            return;
        end
        if (is_num(c)) begin
            add_char(c);
            scan_mode = SCAN_NUMBER;
            return;
        end
        case (c)
            CH_EQ:           kind = KIND_EQ;
            CH_MINUS:        kind = KIND_MINUS;
            CH_STAR:         kind = KIND_STAR;
            CH_LPAREN:       kind = KIND_LPAREN;
            CH_RPAREN:       kind = KIND_RPAREN;
            CH_SEMI, CH_BANG: kind = KIND_SEMI;
            CH_LT: begin
                add_char(c);
                scan_mode = SCAN_LESS;
            end
            CH_GT: begin
                add_char(c);
                scan_mode = SCAN_GREATER;
            end
            CH_COLON: begin
                add_char(c);
                scan_mode = SCAN_COLON;
            end
            CH_NL: begin
                // Raise the count first: the end-of-line token carries the new line.
                if (line_cnt != 16'hFFFF) begin
                    line_cnt = line_cnt + 16'd1;
                end
                queue_token(KIND_EOLN, text_of("EOLN"), '0, 5'd4, 1'b0, ERR_NONE, 8'h00);
            end
            default: queue_token(KIND_ERROR, '0, '0, '0, 1'b0, ERR_CHAR, c);
        endcase
        if (kind != KIND_ERROR) begin
            queue_token(kind, {56'h0, c}, '0, 5'd1, 1'b0, ERR_NONE, 8'h00);
        end
    endfunction

    // Work out every token that one accepted request causes.
    function automatic void predict_request(input logic [7:0] c, input logic eot);
        bit joined;
        joined = 1'b0;
        if (eot) begin
            // Flush, then end of file with the old line count, then back to reset state.
            flush_token();
            queue_token(KIND_EOF, text_of("EOF"), '0, 5'd3, 1'b0, ERR_NONE, 8'h00);
            reset_predictor();
        end else begin
            case (scan_mode)
                SCAN_WORD: begin
                    if (is_alpha(c) || is_num(c)) begin
                        add_char(c);
                        joined = 1'b1;
                    end
                end
                SCAN_NUMBER: begin
                    if (is_num(c)) begin
                        add_char(c);
                        joined = 1'b1;
                    end
                end
                SCAN_LESS: begin
                    if (c == CH_EQ || c == CH_GT) begin
                        add_char(c);
                        emit_buffered(c == CH_EQ ? KIND_LE : KIND_NE);
                        joined = 1'b1;
                    end
                end
                SCAN_GREATER, SCAN_COLON: begin
                    if (c == CH_EQ) begin
                        add_char(c);
                        emit_buffered(scan_mode == SCAN_GREATER ? KIND_GE : KIND_ASSIGN);
                        joined = 1'b1;
                    end
                end
                default: ;
            endcase
            if (joined) begin
                scan_mode = (scan_mode == SCAN_WORD || scan_mode == SCAN_NUMBER) ?
                            scan_mode : SCAN_IDLE;
            end else begin
                flush_token();
                start_char(c);
            end
        end
        // Mark the final token of this byte and release it.
        if (have_held) begin
            held.last = 1'b1;
            pending_tokens.push_back(held);
            have_held = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Token checker: compare every accepted output request with the oldest token owed.
    // ------------------------------------------------------------------
    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_tokens
        t_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_tokens.size() == 0) begin
                $error("token_kind: no token owed, got %0h", out_ch.token_kind);
                fail_count++;
            end else begin
                want = pending_tokens.pop_front();
                check_field("token_kind", 64'(want.token_kind), 64'(out_ch.token_kind));
                check_field("text_low", want.text_low, out_ch.text_low);
                check_field("text_high", want.text_high, out_ch.text_high);
                check_field("text_length", 64'(want.text_length),
                            64'(out_ch.text_length));
                check_field("too_long", 64'(want.too_long), 64'(out_ch.too_long));
                check_field("line_number", 64'(want.line_number),
                            64'(out_ch.line_number));
                check_field("error_kind", 64'(want.error_kind), 64'(out_ch.error_kind));
                check_field("bad_char", 64'(want.bad_char), 64'(out_ch.bad_char));
                check_field("last", 64'(want.last), 64'(out_ch.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Token sink: drive ready with random holds; a long hold on request.
    // ------------------------------------------------------------------
    initial begin : token_sink
        int gap;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request != 0) begin
                // Hold off long enough for the block to fill and stall its input.
                gap          = hold_request;
                hold_request = 0;
            end else begin
                gap = (out_idle_allowed && out_idle_on) ? $urandom_range(0, 19) : 0;
            end
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            // Flip now and then so that stretches without holds occur too.
            if ($urandom_range(0, 39) == 0) begin
                out_idle_on = !out_idle_on;
            end
        end
    end

    // Watchdog: end the run when no request moves on either side for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("testbench NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte source.
    // ------------------------------------------------------------------

    // Offer one byte after a random gap, hold it until accepted, then predict.
    task automatic send_char(input logic [7:0] c, input logic eot = 1'b0);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.char_byte   <= c;
        in_ch.end_of_text <= eot;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_request(c, eot);
        sent_count++;
    endtask

    // End the text; the byte rides along with a random value and must be ignored.
    task automatic send_eot();
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    // Drop valid, wait until every owed token has arrived, then let the pipe settle.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        return (r < 52) ? rand_letter() : 8'("0" + r - 52);
    endfunction

    // Mostly short words; now and then a long one, mostly past the buffer, to force truncation.
    function automatic int rand_word_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(15, 21) : $urandom_range(1, 8);
    endfunction

    // One well-formed lexeme with random content, or noise, or a broken operator.
    task automatic send_random_piece();
        int    pick;
        int    len;
        string word;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            send_text(kw_words[$urandom_range(0, 8)]);
        end else if (pick < 26) begin
            // Near misses: keyword prefix, keyword in capitals, keyword extended.
            word = kw_words[$urandom_range(0, 8)];
            case ($urandom_range(0, 2))
                0:       word = word.substr(0, word.len() - 2);
                1:       word = word.toupper();
                default: word = {word, "x"};
            endcase
            send_text(word);
        end else if (pick < 40) begin
            len = rand_word_len();
            send_char(rand_letter());
            repeat (len - 1) send_char(rand_alnum());
        end else if (pick < 50) begin
            len = rand_word_len();
            repeat (len) send_char(8'("0" + $urandom_range(0, 9)));
        end else if (pick < 72) begin
            send_text(op_words[$urandom_range(0, 12)]);
        end else if (pick < 86) begin
            case ($urandom_range(0, 2))
                0:       send_char(CH_SPACE);
                1:       send_char(CH_TAB);
                default: send_char(CH_NL);
            endcase
        end else if (pick < 94) begin
            send_char(8'($urandom_range(0, 255)));
        end else begin
            // Operator start followed by anything at all.
            case ($urandom_range(0, 2))
                0:       send_char(CH_COLON);
                1:       send_char(CH_LT);
                default: send_char(CH_GT);
            endcase
            send_char(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Every operator except a lone =, a keyword, an identifier and a constant, closed by an end of line.
    task automatic test_operators();
        send_text("if<=1<>b>=:=<(>)-*;!");
        send_char(CH_NL);
        settle();
    endtask

    // Colon error before a newline, invalid bytes at both ends, blanks, and end of
    // text with a colon still pending.
    task automatic test_special_chars();
        send_char(CH_COLON);
        send_char(CH_NL);
        send_char(8'hFF);
        send_char(CH_SPACE);
        send_char(CH_TAB);
        send_char(8'h00);
        send_char(CH_COLON);
        send_char(8'hFF, 1'b1);
        settle();
    endtask

    // Hold the sink off while bytes keep coming so the block fills and stalls its input.
    task automatic test_backpressure();
        in_idle_on       = 1'b0;
        out_idle_allowed = 1'b0;
        hold_request     = HOLD_CYCLES;
        repeat (40) send_text("x(");
        send_eot();
        settle();
        in_idle_on       = 1'b1;
        out_idle_allowed = 1'b1;
    endtask

    // Random source text: mostly lexemes, some noise, texts closed at random.
    task automatic test_random_text();
        int first;
        int pieces;
        first = sent_count;
        while (sent_count - first < RANDOM_ITEMS) begin
            in_idle_on = ($urandom_range(0, 2) != 0);
            pieces     = $urandom_range(4, 30);
            repeat (pieces) begin
                send_random_piece();
                if ($urandom_range(0, 1) == 0) begin
                    send_char($urandom_range(0, 3) == 0 ? CH_NL : CH_SPACE);
                end
            end
            if ($urandom_range(0, 5) == 0) begin
                send_eot();
            end
            if ($urandom_range(0, 9) == 0) begin
                settle();
            end
        end
        send_eot();
        settle();
    endtask

    // Run up the line count, use it in tokens and errors, then end the text to clear it.
    task automatic test_line_count();
        in_idle_on       = 1'b0;
        out_idle_allowed = 1'b0;
        repeat (LINE_RUN_COUNT) send_char(CH_NL);
        send_text("end:");
        send_char(CH_NL);
        send_char(8'h80);
        send_eot();
        send_char(CH_NL);
        send_eot();
        settle();
        in_idle_on       = 1'b1;
        out_idle_allowed = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, run the tests in turn, report.
    // ------------------------------------------------------------------
    initial begin
        fail_count       = 0;
        sent_count       = 0;
        have_held        = 1'b0;
        hold_request     = 0;
        in_idle_on       = 1'b1;
        out_idle_on      = 1'b1;
        out_idle_allowed = 1'b1;
        reset_predictor();
        in_ch.valid       <= 1'b0;
        in_ch.char_byte   <= 8'h00;
        in_ch.end_of_text <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_operators();
        test_special_chars();
        test_backpressure();
        test_random_text();
        test_line_count();

        settle();
        if (fail_count == 0 && pending_tokens.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
